@@ rtl/tlnf_pkg.sv @@
// ----------------------------------------------------------------------------
// tlnf_pkg: shared types and constants of the text line number formatter
// Character codes, item and register codes, and the job word that the front
// end hands to the expansion back end.
// ----------------------------------------------------------------------------
package tlnf_pkg;

  // item codes
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_SOF  = 1'b1;

  // register indexes
  localparam logic [1:0] CFG_SHOW_ENDS   = 2'd0;
  localparam logic [1:0] CFG_SHOW_TABS   = 2'd1;
  localparam logic [1:0] CFG_NUMBER_MODE = 2'd2;

  // numbering modes
  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_ALL      = 2'd1;
  localparam logic [1:0] MODE_NONBLANK = 2'd2;

  // characters
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  // one queued job: optional number, two optional bytes, optional number
  typedef struct packed {
    logic       num_pre;
    logic       b0_en;
    logic [7:0] b0;
    logic       b1_en;
    logic [7:0] b1;
    logic       num_post;
  } tlnf_job_t;

endpackage

@@ rtl/tlnf_front.sv @@
// ----------------------------------------------------------------------------
// tlnf_front: item classifier
// Holds configuration, line counters and the line start flag; turns each
// accepted item into a job word plus the number to print.
// ----------------------------------------------------------------------------
module tlnf_front
  import tlnf_pkg::*;
#(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [1:0]                 cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [7:0]                 in_data_byte,
  input  logic                       q_full,
  output logic                       push,
  output tlnf_job_t                  push_job,
  output logic [4*NUMBER_DIGITS-1:0] push_num
);

  localparam int BCD_W = 4 * NUMBER_DIGITS;
  localparam logic [BCD_W-1:0] BCD_ONE = BCD_W'(1);

  logic             show_ends_r;
  logic             show_tabs_r;
  logic [1:0]       mode_r;
  logic [BCD_W-1:0] line_r, line_nxt;
  logic [BCD_W-1:0] nb_r, nb_nxt;
  logic             start_r, start_nxt;
  logic             acc;
  logic             all_mode, nb_mode;

  // saturating BCD increment
  function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    logic             carry;
    logic [3:0]       d;
    r     = v;
    carry = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      d = v[4*i +: 4];
      if (carry) begin
        if (d >= 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = d + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    if (carry) begin
      r = v;
    end
    return r;
  endfunction

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign all_mode = (mode_r == MODE_ALL);
  assign nb_mode  = (mode_r == MODE_NONBLANK);

  always_comb begin
    push_job  = '0;
    push_num  = line_r;
    line_nxt  = line_r;
    nb_nxt    = nb_r;
    start_nxt = start_r;
    if (in_action == ACT_SOF) begin
      line_nxt  = BCD_ONE;
      nb_nxt    = BCD_ONE;
      start_nxt = 1'b1;
      if (all_mode) begin
        push_job.num_post = 1'b1;
        push_num          = BCD_ONE;
        line_nxt          = bcd_inc(BCD_ONE);
      end
    end else if (in_data_byte == CH_NL) begin
      push_job.b0_en = show_ends_r;
      push_job.b0    = CH_DOLLAR;
      push_job.b1_en = 1'b1;
      push_job.b1    = CH_NL;
      start_nxt      = 1'b1;
      if (all_mode) begin
        push_job.num_post = 1'b1;
        line_nxt          = bcd_inc(line_r);
      end
    end else if (in_data_byte == CH_TAB) begin
      push_job.b1_en = 1'b1;
      if (show_tabs_r) begin
        push_job.b0_en = 1'b1;
        push_job.b0    = CH_CARET;
        push_job.b1    = CH_I;
      end else begin
        push_job.b1    = CH_TAB;
      end
    end else begin
      push_job.b1_en = 1'b1;
      push_job.b1    = in_data_byte;
      start_nxt      = 1'b0;
      if (nb_mode && start_r) begin
        push_job.num_pre = 1'b1;
        push_num         = nb_r;
        nb_nxt           = bcd_inc(nb_r);
      end
    end
  end

  // drop items that expand to nothing
  assign push = acc && (push_job.num_post || push_job.b1_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_ends_r <= 1'b0;
      show_tabs_r <= 1'b0;
      mode_r      <= MODE_NONE;
      line_r      <= BCD_ONE;
      nb_r        <= BCD_ONE;
      start_r     <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SHOW_ENDS:   show_ends_r <= cfg_wdata[0];
          CFG_SHOW_TABS:   show_tabs_r <= cfg_wdata[0];
          CFG_NUMBER_MODE: mode_r      <= cfg_wdata;
          default: ;
        endcase
      end
      if (acc) begin
        line_r  <= line_nxt;
        nb_r    <= nb_nxt;
        start_r <= start_nxt;
      end
    end
  end

  a_sof_resets_nb: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_action == ACT_SOF) |=> (nb_r == BCD_ONE && start_r))
    else $error("start of file did not reset nonblank counter");

endmodule

@@ rtl/tlnf_queue.sv @@
// ----------------------------------------------------------------------------
// tlnf_queue: two-entry job queue
// Decouples the classifier from the expansion sequencer.
// ----------------------------------------------------------------------------
module tlnf_queue
  import tlnf_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              not_empty
);

  localparam int DEPTH = 2;

  logic [DATA_W-1:0] entry_r [DEPTH];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r;

  assign full      = (count_r == 2'(DEPTH));
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(DEPTH))
    else $error("job queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0) |-> !pop)
    else $error("pop from empty job queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full job queue");

endmodule

@@ rtl/tlnf_back.sv @@
// ----------------------------------------------------------------------------
// tlnf_back: expansion sequencer
// Walks one job a byte at a time into the output register: number, bytes,
// number; blanks leading zeros of the number.
// ----------------------------------------------------------------------------
module tlnf_back
  import tlnf_pkg::*;
#(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  tlnf_job_t                  q_job,
  input  logic [4*NUMBER_DIGITS-1:0] q_num,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_last_of_run
);

  localparam int BCD_W   = 4 * NUMBER_DIGITS;
  localparam int NUM_LEN = NUMBER_DIGITS + 2;
  localparam int CNT_W   = $clog2(NUM_LEN);

  typedef enum logic [2:0] {P_PRE, P_B0, P_B1, P_POST, P_DONE} phase_t;

  tlnf_job_t        job_r;
  logic [BCD_W-1:0] num_r;
  phase_t           phase_r, phase_next;
  logic [CNT_W-1:0] cnt_r;
  logic             leading_r, leading_nxt;
  logic             cur_valid_r;
  logic             out_valid_r, out_last_r;
  logic [7:0]       out_byte_r;
  logic             adv, done, is_last, blank;
  logic [7:0]       cur_byte, num_byte;
  logic [CNT_W-1:0] rev_idx;
  logic [BCD_W-1:0] shifted;
  logic [3:0]       digit;

  // first enabled phase at or after the given one
  function automatic phase_t skip_from(input tlnf_job_t j, input logic [2:0] from);
    phase_t r;
    r = P_DONE;
    if (from <= 3'(P_POST) && j.num_post) r = P_POST;
    if (from <= 3'(P_B1) && j.b1_en) r = P_B1;
    if (from <= 3'(P_B0) && j.b0_en) r = P_B0;
    if (from == 3'(P_PRE) && j.num_pre) r = P_PRE;
    return r;
  endfunction

  assign rev_idx = CNT_W'(NUMBER_DIGITS - 1) - cnt_r;
  assign shifted = num_r >> {rev_idx, 2'b00};

  always_comb begin
    digit = shifted[3:0];
    if (digit > 4'd9) begin
      digit = 4'd9;
    end
    blank       = leading_r && (digit == 4'd0) && (cnt_r != CNT_W'(NUMBER_DIGITS - 1));
    leading_nxt = blank;
    if (cnt_r < CNT_W'(NUMBER_DIGITS)) begin
      num_byte = blank ? CH_SPACE : (CH_ZERO + {4'd0, digit});
    end else begin
      num_byte = CH_SPACE;
    end
  end

  always_comb begin
    cur_byte = num_byte;
    done     = 1'b0;
    unique case (phase_r)
      P_PRE, P_POST: done = (cnt_r == CNT_W'(NUM_LEN - 1));
      P_B0: begin
        cur_byte = job_r.b0;
        done     = 1'b1;
      end
      P_B1: begin
        cur_byte = job_r.b1;
        done     = 1'b1;
      end
      default: done = 1'b1;
    endcase
    phase_next = skip_from(job_r, 3'(phase_r) + 3'd1);
    is_last    = done && (phase_next == P_DONE);
  end

  assign adv = cur_valid_r && (!out_valid_r || !out_stall);
  assign pop = q_valid && (!cur_valid_r || (adv && is_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= P_DONE;
      cnt_r       <= '0;
      leading_r   <= 1'b1;
    end else begin
      // output register
      if (adv) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= cur_byte;
        out_last_r  <= is_last;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      // sequencer
      if (pop) begin
        job_r       <= q_job;
        num_r       <= q_num;
        phase_r     <= skip_from(q_job, 3'(P_PRE));
        cnt_r       <= '0;
        leading_r   <= 1'b1;
        cur_valid_r <= 1'b1;
      end else if (adv) begin
        if (done) begin
          phase_r   <= phase_next;
          cnt_r     <= '0;
          leading_r <= 1'b1;
          if (is_last) begin
            cur_valid_r <= 1'b0;
          end
        end else begin
          cnt_r     <= cnt_r + CNT_W'(1);
          leading_r <= leading_nxt;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

  a_busy_has_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (phase_r != P_DONE))
    else $error("active job without a phase");

  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_last && !q_valid) |=> !cur_valid_r)
    else $error("job still active after its last byte");

endmodule

@@ rtl/text_line_number_formatter_unit.sv @@
// ----------------------------------------------------------------------------
// text_line_number_formatter_unit: line numbering and show-ends/tabs
// Formats a byte stream with optional line numbers, '$' before newlines and
// caret-I for tabs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word per cycle, either a start of
//   file (in_action = 1) or a data byte. A word is taken when in_valid is high
//   and in_stall is low; in_stall rises only when the two-entry job queue is
//   full.
//   Output channel (out_valid / out_stall): the formatted bytes of each word;
//   out_last_of_run marks the final byte produced by one input word.
//   Throughput is set by the expansion sequencer: one byte per cycle unless
//   the receiver stalls. An accepted word passes the job queue and the
//   sequencer's job register before its first byte reaches the output
//   register. A start of file outside all-lines mode produces no output byte.
//   Configuration (cfg_we / cfg_index / cfg_wdata) must be written only
//   while idle; the block does not enforce it.
//   Reset clears registers, counters to one, the queue and the output stage.
//   When the receiver stalls, the output word holds, the queue fills and
//   then the input side stalls; nothing is dropped.
// ----------------------------------------------------------------------------
module text_line_number_formatter_unit
  import tlnf_pkg::*;
#(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  localparam int BCD_W = 4 * NUMBER_DIGITS;
  localparam int JOB_W = $bits(tlnf_job_t) + BCD_W;

  // front to queue
  logic             push;
  tlnf_job_t        push_job;
  logic [BCD_W-1:0] push_num;
  logic             q_full;

  // queue to back
  logic             pop;
  logic             q_valid;
  logic [JOB_W-1:0] q_data;
  tlnf_job_t        q_job;
  logic [BCD_W-1:0] q_num;

  // classify words and track counters
  tlnf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_data_byte(in_data_byte),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job),
    .push_num    (push_num)
  );

  // hold jobs while the back end expands earlier ones
  tlnf_queue #(
    .DATA_W(JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_job, push_num}),
    .full     (q_full),
    .pop      (pop),
    .pop_data (q_data),
    .not_empty(q_valid)
  );

  assign q_job = q_data[JOB_W-1:BCD_W];
  assign q_num = q_data[BCD_W-1:0];

  // expand each job into output words
  tlnf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_job          (q_job),
    .q_num          (q_num),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of text_line_number_formatter_unit
// Drives start-of-file and data words into the formatter and predicts every
// formatted byte in a scoreboard class. The checks cover line numbers,
// dollar signs before newlines and caret-I tabs under several register
// settings, with random idling on both channels and one long receiver hold.
// ----------------------------------------------------------------------------
module tb;
  import tlnf_pkg::*;

  localparam int DIGITS = 6;
  localparam int BCD_W  = 4 * DIGITS;

  // one formatted byte as the output channel moves it
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } fmt_char_t;

  // Predicts the formatted stream and checks the output against it.
  class fmt_scoreboard;
    logic             show_ends;
    logic             show_tabs;
    logic [1:0]       number_mode;
    logic [BCD_W-1:0] line_no;
    logic [BCD_W-1:0] nonblank_no;
    bit               at_line_start;
    fmt_char_t        run_q[$];
    fmt_char_t        exp_q[$];
    int               errors;

    function new();
      show_ends     = 1'b0;
      show_tabs     = 1'b0;
      number_mode   = MODE_NONE;
      line_no       = 1;
      nonblank_no   = 1;
      at_line_start = 1'b1;
      errors        = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [1:0] val);
      case (idx)
        CFG_SHOW_ENDS:   show_ends   = val[0];
        CFG_SHOW_TABS:   show_tabs   = val[0];
        CFG_NUMBER_MODE: number_mode = val;
        default: ;
      endcase
    endfunction

    // saturating BCD increment: all nines stays all nines
    function logic [BCD_W-1:0] bcd_next(logic [BCD_W-1:0] v);
      logic [BCD_W-1:0] r;
      int               i;
      r = v;
      for (i = 0; i < DIGITS; i++) begin
        if (r[4*i +: 4] < 4'd9) begin
          r[4*i +: 4] = r[4*i +: 4] + 4'd1;
          return r;
        end
        r[4*i +: 4] = 4'd0;
      end
      return v;
    endfunction

    function void emit(logic [7:0] b);
      fmt_char_t c;
      c.ch   = b;
      c.last = 1'b0;
      run_q.push_back(c);
    endfunction

    // right-aligned number, leading zeros blanked, then two spaces
    function void emit_number(logic [BCD_W-1:0] v);
      bit         leading;
      logic [3:0] d;
      int         i;
      leading = 1'b1;
      for (i = DIGITS; i > 0; i--) begin
        d = v[4*(i-1) +: 4];
        if (d > 4'd9) d = 4'd9;
        if (leading && d == 4'd0 && i > 1) begin
          emit(CH_SPACE);
        end else begin
          leading = 1'b0;
          emit(CH_ZERO + {4'd0, d});
        end
      end
      emit(CH_SPACE);
      emit(CH_SPACE);
    endfunction

    // Note one accepted input word and queue the bytes it causes.
    function void note_word(logic act, logic [7:0] b);
      bit        all_mode;
      bit        nb_mode;
      fmt_char_t c;
      int        i;
      all_mode = (number_mode == MODE_ALL);
      nb_mode  = (number_mode == MODE_NONBLANK);
      run_q.delete();
      if (act == ACT_SOF) begin
        line_no       = 1;
        nonblank_no   = 1;
        at_line_start = 1'b1;
        if (all_mode) begin
          emit_number(line_no);
          line_no = bcd_next(line_no);
        end
      end else if (b == CH_NL) begin
        if (show_ends) emit(CH_DOLLAR);
        emit(CH_NL);
        if (all_mode) begin
          emit_number(line_no);
          line_no = bcd_next(line_no);
        end
        at_line_start = 1'b1;
      end else if (b == CH_TAB) begin
        if (show_tabs) begin
          emit(CH_CARET);
          emit(CH_I);
        end else begin
          emit(CH_TAB);
        end
      end else begin
        if (nb_mode && at_line_start) begin
          emit_number(nonblank_no);
          nonblank_no = bcd_next(nonblank_no);
        end
        emit(b);
        at_line_start = 1'b0;
      end
      for (i = 0; i < run_q.size(); i++) begin
        c      = run_q[i];
        c.last = (i == run_q.size() - 1);
        exp_q.push_back(c);
      end
    endfunction

    // Check one accepted output byte against the oldest prediction.
    function void check_result(logic [7:0] b, logic last);
      fmt_char_t e;
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output: byte %h last %b", b, last);
        return;
      end
      e = exp_q.pop_front();
      if (e.ch !== b || e.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("output mismatch: expected byte %h last %b, got byte %h last %b",
                   e.ch, e.last, b, last);
      end
    endfunction
  endclass

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       cfg_we       = 1'b0;
  logic [1:0] cfg_index    = CFG_SHOW_ENDS;
  logic [1:0] cfg_wdata    = 2'd0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic       in_action    = ACT_DATA;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] out_byte;
  logic       out_last_of_run;

  fmt_scoreboard sb = new();

  // idle limits per side, and a one-shot long hold for the receiver
  int in_gap_max  = 10;
  int out_gap_max = 10;
  int out_hold    = 0;

  text_line_number_formatter_unit #(
    .NUMBER_DIGITS(DIGITS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sample both handshakes at the rising edge. A word accepted on the input
  // cannot show up on the output at the same edge, so note before check.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_word(in_action, in_data_byte);
      if (out_valid && !out_stall) sb.check_result(out_byte, out_last_of_run);
    end
  end

  // Receiver: before each word, hold stall for a drawn number of cycles.
  // A pending long hold takes the place of one draw.
  initial begin : out_side
    int n;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (out_hold > 0) begin
        n        = out_hold;
        out_hold = 0;
      end else begin
        n = $urandom_range(0, out_gap_max);
      end
      repeat (n) begin
        out_stall <= 1'b1;
        @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Offer one word after a random gap; return at the falling edge after it is
  // taken, with valid left high so a back-to-back word needs no re-raise.
  task automatic send_word(input logic act, input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid, drain every predicted byte, then let a start-of-file that
  // caused nothing clear the pipe before registers change.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.exp_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Write all three registers back to back while idle.
  task automatic program_regs(input logic [1:0] ends_v, input logic [1:0] tabs_v,
                              input logic [1:0] mode_v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SHOW_ENDS;
    cfg_wdata <= ends_v;
    sb.set_reg(CFG_SHOW_ENDS, ends_v);
    @(negedge clk);
    cfg_index <= CFG_SHOW_TABS;
    cfg_wdata <= tabs_v;
    sb.set_reg(CFG_SHOW_TABS, tabs_v);
    @(negedge clk);
    cfg_index <= CFG_NUMBER_MODE;
    cfg_wdata <= mode_v;
    sb.set_reg(CFG_NUMBER_MODE, mode_v);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One random file stream: starts with a start-of-file, then mostly text
  // with newlines and tabs, some raw bytes as noise and rare new files.
  task automatic run_text(input int n_items, input int nl_pct, input int noise_pct,
                          input int sof_pct);
    int         k;
    int         r;
    logic [7:0] b;
    send_word(ACT_SOF, 8'($urandom));
    for (k = 1; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < sof_pct) begin
        send_word(ACT_SOF, 8'($urandom));
      end else begin
        if (r < sof_pct + nl_pct) b = CH_NL;
        else if (r < sof_pct + nl_pct + 8) b = CH_TAB;
        else if (r < sof_pct + nl_pct + 8 + noise_pct) b = 8'($urandom);
        else b = 8'($urandom_range(8'h20, 8'h7E));
        send_word(ACT_DATA, b);
      end
    end
    settle();
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings, data before any start-of-file: no number appears.
    send_word(ACT_DATA, 8'h61);
    send_word(ACT_DATA, CH_NL);
    send_word(ACT_DATA, CH_TAB);
    send_word(ACT_DATA, 8'h00);
    send_word(ACT_DATA, 8'hFF);
    send_word(ACT_SOF, 8'hFF);
    settle();

    // All lines numbered, ends and tabs shown; trailing number after last line.
    program_regs(2'd1, 2'd1, MODE_ALL);
    send_word(ACT_SOF, 8'h00);
    send_word(ACT_DATA, 8'h78);
    send_word(ACT_DATA, CH_TAB);
    send_word(ACT_DATA, CH_NL);
    send_word(ACT_DATA, CH_NL);
    settle();

    // Nonblank numbering: a leading tab and a blank line get no number.
    program_regs(2'd0, 2'd0, MODE_NONBLANK);
    send_word(ACT_SOF, 8'hA5);
    send_word(ACT_DATA, CH_TAB);
    send_word(ACT_DATA, 8'h79);
    send_word(ACT_DATA, CH_NL);
    send_word(ACT_DATA, CH_NL);
    send_word(ACT_DATA, 8'h7A);
    settle();

    // Mode three numbers nothing; the upper data bit is ignored.
    program_regs(2'd3, 2'd2, 2'd3);
    send_word(ACT_SOF, 8'h5A);
    send_word(ACT_DATA, 8'h71);
    send_word(ACT_DATA, CH_NL);
    send_word(ACT_DATA, CH_TAB);
    settle();

    // Random phases.
    in_gap_max  = 10;
    out_gap_max = 10;
    program_regs(2'd1, 2'd1, MODE_ALL);
    run_text(45, 12, 5, 3);

    in_gap_max  = 0;
    out_gap_max = 0;
    program_regs(2'd0, 2'd0, MODE_NONBLANK);
    run_text(45, 15, 5, 3);

    in_gap_max  = 0;
    out_gap_max = 10;
    program_regs(2'($urandom), 2'($urandom), MODE_NONE);
    run_text(45, 12, 10, 3);

    in_gap_max  = 10;
    out_gap_max = 0;
    program_regs(2'($urandom), 2'($urandom), 2'd3);
    run_text(30, 12, 10, 5);

    // Long receiver hold while the sender keeps offering: fills the queue.
    in_gap_max  = 0;
    out_gap_max = 0;
    out_hold    = 400;
    program_regs(2'd1, 2'd0, MODE_ALL);
    run_text(45, 15, 5, 2);

    in_gap_max  = 10;
    out_gap_max = 0;
    program_regs(2'd1, 2'd1, MODE_NONBLANK);
    run_text(45, 15, 5, 3);

    // Mostly newlines in one file: carries the line number past 99.
    in_gap_max  = 0;
    out_gap_max = 3;
    program_regs(2'd0, 2'd1, MODE_ALL);
    run_text(160, 70, 5, 0);

    in_gap_max  = 10;
    out_gap_max = 10;
    program_regs(2'($urandom), 2'($urandom), 2'($urandom));
    run_text(45, 12, 15, 4);

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
rtl/tlnf_pkg.sv
rtl/tlnf_front.sv
rtl/tlnf_queue.sv
rtl/tlnf_back.sv
rtl/text_line_number_formatter_unit.sv
dv/tb.sv
